@@ src/ras_pkg.sv @@
// ----------------------------------------------------------------------------
// ras_pkg
// Shared constants and controller/datapath interface types for the rotated
// sorted table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package ras_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;

  // Field widths fixed by the interface.
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 10;
  localparam int MATCH_W = 11;

  // Operation codes carried by op_i.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Answer when the key is not in the table.
  localparam logic [MATCH_W-1:0] NOT_FOUND = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // write one table entry from the input transaction
    logic start_search; // capture the key and open the bounds
    logic step_low;     // keep the lower half: end = mid - 1
    logic step_high;    // keep the upper half: start = mid + 1
    logic rd_end;       // read the word at the end bound on port A
    logic load_result;  // capture the answer into the output register
  } ras_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;        // start bound has passed the end bound
    logic hit;          // middle word equals the key
    logic lower_sorted; // start word <= middle word
    logic key_in_lower; // start word <= key <= middle word
    logic key_in_upper; // middle word <= key <= end word
  } ras_status_t;

endpackage

`default_nettype wire

@@ src/rotated_array_search.sv @@
// ----------------------------------------------------------------------------
// rotated_array_search
// Binary search for a key in a loaded table that holds a rotated ascending
// list of signed 32-bit words.
// ----------------------------------------------------------------------------
// A load transaction (op 0) writes one table word and returns nothing. A
// search transaction (op 1) returns the index of a word equal to the key,
// or -1. A search first opens the bounds and then runs its probes; a probe
// also reads the end word in the ST_ENDRD state when the lower half is not
// sorted, because the table memory has two read ports and such a probe
// needs the start, middle and end words. With 1024 entries that is about 11
// probes, after which the answer is handed to the output register. The
// output register frees the block for the next transaction while an answer
// waits to be taken. entry_count is written through cfg_we_i/cfg_data_i; the
// user must do so only while the block is idle, and the block itself does
// not enforce this. Values above 1024 are treated as 1024. Only entries
// below entry_count are ever read, and they must have been loaded first.
`default_nettype none

module rotated_array_search (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input transaction channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              op_i,
  input  wire logic [ras_pkg::INDEX_W-1:0]       entry_index_i,
  input  wire logic signed [ras_pkg::WORD_W-1:0] entry_value_i,
  input  wire logic signed [ras_pkg::WORD_W-1:0] search_key_i,
  // Result transaction channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [ras_pkg::MATCH_W-1:0]     match_index_o,
  // entry_count register write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [ras_pkg::COUNT_W-1:0]       cfg_data_i
);

  ras_pkg::ras_cmd_t    cmd;
  ras_pkg::ras_status_t status;

  // The sequencer owns both handshakes and decides each probe step.
  ras_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the table, the bounds and the comparators.
  ras_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .match_index_o (match_index_o)
  );

endmodule

`default_nettype wire

@@ src/ras_dpath.sv @@
// ----------------------------------------------------------------------------
// ras_dpath
// Table memory, search bounds, key register, comparators and the result
// register of the rotated sorted table search.
// ----------------------------------------------------------------------------
`default_nettype none

module ras_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ras_pkg::ras_cmd_t                 cmd_i,
  output ras_pkg::ras_status_t                   status_o,
  input  wire logic [ras_pkg::INDEX_W-1:0]       entry_index_i,
  input  wire logic signed [ras_pkg::WORD_W-1:0] entry_value_i,
  input  wire logic signed [ras_pkg::WORD_W-1:0] search_key_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [ras_pkg::COUNT_W-1:0]       cfg_data_i,
  output logic signed [ras_pkg::MATCH_W-1:0]     match_index_o
);

  localparam int AW = ras_pkg::ADDR_W;
  localparam int CW = ras_pkg::COUNT_W;

  logic [ras_pkg::WORD_W-1:0] mem [ras_pkg::TABLE_DEPTH];

  logic [CW-1:0]                      entry_count_q;
  logic [CW-1:0]                      count_sat;
  logic [CW-1:0]                      start_q, start_d;
  logic [CW-1:0]                      limit_q, limit_d;  // end bound plus one
  logic signed [ras_pkg::WORD_W-1:0]  key_q;
  logic signed [ras_pkg::WORD_W-1:0]  rd_a_q, rd_b_q;
  logic [ras_pkg::MATCH_W-1:0]        match_q;
  logic [CW:0]                        sum_cur, sum_nxt;
  logic [AW-1:0]                      mid_cur, mid_nxt;
  logic [CW-1:0]                      end_cur;
  logic [AW-1:0]                      addr_a, addr_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  assign count_sat = (entry_count_q > CW'(ras_pkg::TABLE_DEPTH)) ?
                     CW'(ras_pkg::TABLE_DEPTH) : entry_count_q;

  // Middle of the current bounds; only meaningful while start < limit.
  assign sum_cur = {1'b0, start_q} + {1'b0, limit_q} - (CW+1)'(1);
  assign mid_cur = sum_cur[AW:1];
  assign end_cur = limit_q - CW'(1);

  always_comb begin
    start_d = start_q;
    limit_d = limit_q;
    if (cmd_i.start_search) begin
      start_d = '0;
      limit_d = count_sat;
    end else if (cmd_i.step_low) begin
      limit_d = {1'b0, mid_cur};
    end else if (cmd_i.step_high) begin
      start_d = {1'b0, mid_cur} + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      limit_q <= '0;
    end else begin
      start_q <= start_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_search) begin
      key_q <= search_key_i;
    end
  end

  // Reads are addressed from the next bounds so the words arrive together
  // with the bounds they belong to.
  assign sum_nxt = {1'b0, start_d} + {1'b0, limit_d} - (CW+1)'(1);
  assign mid_nxt = sum_nxt[AW:1];
  assign addr_a  = cmd_i.rd_end ? end_cur[AW-1:0] : start_d[AW-1:0];
  assign addr_b  = mid_nxt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(entry_index_i) < ras_pkg::TABLE_DEPTH)) begin
      mem[entry_index_i[AW-1:0]] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Port A carries the start word in a probe and the end word after rd_end.
  assign status_o.empty        = !(start_q < limit_q);
  assign status_o.hit          = (rd_b_q == key_q);
  assign status_o.lower_sorted = (rd_a_q <= rd_b_q);
  assign status_o.key_in_lower = (rd_a_q <= key_q) && (key_q <= rd_b_q);
  assign status_o.key_in_upper = (rd_a_q >= key_q) && (key_q >= rd_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      match_q <= (!status_o.empty && status_o.hit) ?
                 ras_pkg::MATCH_W'(mid_cur) : ras_pkg::NOT_FOUND;
    end
  end

  assign match_index_o = match_q;

endmodule

`default_nettype wire

@@ src/ras_ctrl.sv @@
// ----------------------------------------------------------------------------
// ras_ctrl
// Search sequencer: input and output handshakes and the probe state machine
// of the rotated sorted table search.
// ----------------------------------------------------------------------------
`default_nettype none

module ras_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ras_pkg::ras_cmd_t      cmd_o,
  input  wire ras_pkg::ras_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_ENDRD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == ras_pkg::OP_SEARCH) begin
            cmd_o.start_search = 1'b1;
            state_d            = ST_PROBE;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.empty || status_i.hit) begin
          // Hold the bounds until the output register can take the answer.
          if (slot_free) begin
            cmd_o.load_result = 1'b1;
            out_valid_d       = 1'b1;
            state_d           = ST_IDLE;
          end
        end else if (status_i.lower_sorted) begin
          if (status_i.key_in_lower) begin
            cmd_o.step_low = 1'b1;
          end else begin
            cmd_o.step_high = 1'b1;
          end
        end else begin
          cmd_o.rd_end = 1'b1;
          state_d      = ST_ENDRD;
        end
      end
      ST_ENDRD: begin
        if (status_i.key_in_upper) begin
          cmd_o.step_high = 1'b1;
        end else begin
          cmd_o.step_low = 1'b1;
        end
        state_d = ST_PROBE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ bench/ras_search_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_search_checker
// Watches the transaction, result and entry_count ports of the rotated table
// search block, keeps its own copy of the table, predicts each search answer
// and compares it with the result that comes out.
// ----------------------------------------------------------------------------

module ras_search_checker
  import ras_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      op_i,
  input  logic [INDEX_W-1:0]        entry_index_i,
  input  logic signed [WORD_W-1:0]  entry_value_i,
  input  logic signed [WORD_W-1:0]  search_key_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [MATCH_W-1:0] match_index_i,
  input  logic                      cfg_we_i,
  input  logic [COUNT_W-1:0]        cfg_data_i,
  output int                        mismatches_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [WORD_W-1:0] key;
    logic [MATCH_W-1:0]       match;
  } search_expect_t;

  logic signed [WORD_W-1:0] entry_words [TABLE_DEPTH];
  logic [COUNT_W-1:0]       entry_count_q;
  search_expect_t           expected_matches [$];
  int                       mismatch_count;
  int                       pending_count;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  // Binary search over the words below entry_count, probing the same words in
  // the same order as the hardware does.
  function automatic logic [MATCH_W-1:0] search_rotated(input logic signed [WORD_W-1:0] key);
    int lo_bound;
    int hi_bound;
    int mid;
    logic signed [WORD_W-1:0] w_lo;
    logic signed [WORD_W-1:0] w_mid;
    logic signed [WORD_W-1:0] w_hi;
    lo_bound = 0;
    hi_bound = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entry_count_q) - 1;
    while (lo_bound <= hi_bound) begin
      mid   = lo_bound + (hi_bound - lo_bound) / 2;
      w_lo  = entry_words[lo_bound];
      w_mid = entry_words[mid];
      w_hi  = entry_words[hi_bound];
      if (w_mid == key) return MATCH_W'(mid);
      if (w_lo <= w_mid) begin
        if (w_lo <= key && key <= w_mid) hi_bound = mid - 1;
        else lo_bound = mid + 1;
      end else begin
        if (w_hi >= key && key >= w_mid) lo_bound = mid + 1;
        else hi_bound = mid - 1;
      end
    end
    return NOT_FOUND;
  endfunction

  task automatic flag(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    search_expect_t head;
    if (!rst_ni) begin
      entry_count_q = '0;
      expected_matches.delete();
    end else begin
      // Results are retired before new searches are queued, so a result and a
      // transaction at the same edge never pair up with each other.
      if (out_valid_i && out_ready_i) begin
        if (expected_matches.size() == 0) begin
          flag($sformatf("result %0d arrived with no search outstanding",
                         $signed(match_index_i)));
        end else begin
          head = expected_matches.pop_front();
          if (match_index_i !== head.match) begin
            flag($sformatf("search for key %0d answered %0d, expected %0d",
                           head.key, $signed(match_index_i), $signed(head.match)));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_LOAD) begin
          entry_words[entry_index_i] = entry_value_i;
        end else begin
          head.key   = search_key_i;
          head.match = search_rotated(search_key_i);
          expected_matches.push_back(head);
        end
      end
      if (cfg_we_i) entry_count_q = cfg_data_i;
    end
    pending_count = expected_matches.size();
  end

endmodule

@@ bench/rotated_array_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_array_search_tb
// Loads rotated ascending lists, some broken or unsorted, at many table sizes
// from empty to beyond the table depth, and fires search keys at them under
// random input gaps and output stalls; the checker judges every answer.
// ----------------------------------------------------------------------------

module rotated_array_search_tb;
  import ras_pkg::*;

  // Long enough for a full search to reach the output register, which is how
  // long a trailing load or search may still be busy.
  localparam int SETTLE_CYCLES = 40;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      op_i          = OP_LOAD;
  logic [INDEX_W-1:0]        entry_index_i = '0;
  logic signed [WORD_W-1:0]  entry_value_i = '0;
  logic signed [WORD_W-1:0]  search_key_i  = '0;
  logic                      out_ready_i   = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [COUNT_W-1:0]        cfg_data_i    = '0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic signed [MATCH_W-1:0] match_index_o;

  int mismatches;
  int pending;

  // What the stimulus side has written to the table, so that searches only
  // ever cover entries that hold a loaded word.
  logic signed [WORD_W-1:0] shadow [TABLE_DEPTH];
  bit                       loaded [TABLE_DEPTH];

  int burst_left;
  int load_count;
  int query_count;
  int phase_count;
  int top_count;
  int delivered;

  always #5 clk_i = ~clk_i;

  rotated_array_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_o (match_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  ras_search_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_i (match_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Count result transactions so that the receiver knows when to hold off.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) delivered <= delivered + 1;
  end

  // Offer one transaction. The sender works in bursts: when a burst is used
  // up, valid drops for a random gap (sometimes none) and a new burst length
  // is drawn. Once valid is high it stays high, payload fixed, until the
  // transaction is taken at a rising edge.
  task automatic offer(input logic op, input logic [INDEX_W-1:0] idx,
                       input logic signed [WORD_W-1:0] val,
                       input logic signed [WORD_W-1:0] key);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    search_key_i  <= key;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD) load_count++;
    else query_count++;
  endtask

  // The unused fields of each transaction carry random bits as well.
  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic signed [WORD_W-1:0] val);
    offer(OP_LOAD, idx, val, $urandom());
    shadow[idx] = val;
    loaded[idx] = 1'b1;
  endtask

  task automatic send_query(input logic signed [WORD_W-1:0] key);
    offer(OP_SEARCH, INDEX_W'($urandom()), $urandom(), key);
  endtask

  // Stop offering and wait until every search has been answered.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Loads return nothing, so after the last answer a load may still be in
  // the block; wait out a full search before touching entry_count.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_count(input int count);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= count[COUNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One phase: set entry_count, make sure every entry it covers holds a
  // loaded word, then run searches with a few stray loads mixed in.
  task automatic run_phase(input int count, input int queries);
    int m;
    int mode;
    int rot;
    int pick;
    bit reuse;
    longint run_val;
    longint step_min;
    longint step_max;
    logic signed [WORD_W-1:0] vals [TABLE_DEPTH];
    logic signed [WORD_W-1:0] key;
    m = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    settle();
    write_count(count);
    phase_count++;
    if (count > top_count) top_count = count;

    // A full table is reloaded only when some entry is still missing; small
    // tables are now and then searched again with their old contents.
    reuse = (m > 0);
    for (int i = 0; i < m; i++) if (!loaded[i]) reuse = 1'b0;
    if (m > 0 && !(reuse && (m == TABLE_DEPTH || $urandom_range(0, 3) == 0))) begin
      // Mode 0 makes dense runs with repeated words, mode 1 close neighbors,
      // mode 7 no order at all, and the rest spread over the whole word range.
      mode     = $urandom_range(0, 7);
      step_min = 1;
      if (mode == 0) begin
        step_min = 0;
        step_max = 2;
        run_val  = longint'($signed($urandom()));
      end else if (mode == 1) begin
        step_max = 8;
        run_val  = longint'($signed($urandom()));
      end else begin
        step_max = 64'd4294967295 / (m + 1);
        run_val  = longint'($urandom_range(0, 32'(step_max))) - 64'sd2147483648;
      end
      for (int i = 0; i < m; i++) begin
        if (mode == 7) begin
          vals[i] = $urandom();
        end else begin
          vals[i] = (run_val > 64'sd2147483647) ? WORD_MAX : run_val[WORD_W-1:0];
          run_val += longint'($urandom_range(32'(step_min), 32'(step_max)));
        end
      end
      rot = $urandom_range(0, m - 1);
      for (int i = 0; i < m; i++) send_load(INDEX_W'(i), vals[(i + rot) % m]);
    end

    for (int q = 0; q < queries; q++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_load((m > 0 && $urandom_range(0, 1)) ? INDEX_W'($urandom_range(0, m - 1))
                                                   : INDEX_W'($urandom()), $urandom());
      end
      if ($urandom_range(0, 19) == 0) drain();
      // Mostly keys that are in the table, then their neighbors, the word
      // extremes and plain random words.
      pick = $urandom_range(0, 9);
      if (m > 0 && pick < 5) key = shadow[$urandom_range(0, m - 1)];
      else if (m > 0 && pick < 7) key = shadow[$urandom_range(0, m - 1)] + ((pick == 5) ? 1 : -1);
      else if (pick == 7) key = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
      else key = $urandom();
      send_query(key);
    end
  endtask

  // Receiver: ready follows a pattern that is periodically redrawn. Once,
  // after a few dozen results and while the sender is busy, it holds ready
  // low so that the block fills up and stalls its input.
  initial begin
    int mode;
    int tick;
    bit held;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && delivered >= 60 && in_valid_i) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (tick % 48 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (tick % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table after reset: every search misses.
    send_query(WORD_MIN);
    send_query(WORD_MAX);
    send_query(0);
    // Word extremes at both ends, and a load to the last table position.
    send_load(INDEX_W'(0), WORD_MIN);
    send_load(INDEX_W'(1), WORD_MAX);
    send_load(INDEX_W'(TABLE_DEPTH - 1), 0);
    settle();
    write_count(1);
    send_query(WORD_MIN);
    send_query(WORD_MAX);
    settle();
    write_count(2);
    send_query(WORD_MAX);
    send_query(WORD_MIN);
    send_query(-1);
    // A rotated list with its smallest word in the middle.
    send_load(INDEX_W'(0), 40);
    send_load(INDEX_W'(1), 50);
    send_load(INDEX_W'(2), -30);
    send_load(INDEX_W'(3), 0);
    send_load(INDEX_W'(4), 20);
    settle();
    write_count(5);
    send_query(50);
    send_query(-30);
    send_query(20);
    send_query(40);
    send_query(5);

    // Random phases over small tables, with the occasional empty one.
    while (load_count + query_count < 620) begin
      case ($urandom_range(0, 15))
        0:       run_phase(0, $urandom_range(6, 24));
        1:       run_phase(1, $urandom_range(6, 24));
        2:       run_phase(2, $urandom_range(6, 24));
        default: run_phase($urandom_range(3, 48), $urandom_range(6, 24));
      endcase
    end
    // A few phases at the full depth and with counts past it, which the
    // block treats as the full depth.
    run_phase(TABLE_DEPTH, 40);
    run_phase((1 << COUNT_W) - 1, 30);
    run_phase($urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 2), 20);
    run_phase($urandom_range(3, 20), 16);
    settle();

    $display("Ran %0d loads and %0d searches in %0d phases, entry_count from 0 up to %0d,",
             load_count, query_count, phase_count, top_count);
    $display("with bursty input, random and long output stalls, and %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("rotated_array_search_tb: PASS");
    end else begin
      $display("rotated_array_search_tb: FAIL");
    end
    $finish;
  end

  // The slowest legal run needs well under a millisecond.
  initial begin
    #5_000_000;
    $display("Timed out with %0d searches still unanswered.", pending);
    $display("rotated_array_search_tb: FAIL");
    $finish;
  end

endmodule
